[rtl/lsbame_pkg.sv]
// ----------------------------------------------------------------------------
// LSB audio message extract - shared definitions
// Widths and constants for the LSB message extractor.
// ----------------------------------------------------------------------------
package lsbame_pkg;

    // sample and header widths
    localparam int SAMPLE_BITS = 16;
    localparam int LENGTH_BITS = 32;
    localparam int BYTE_BITS   = 8;
    localparam int MAXLEN_BITS = LENGTH_BITS - 1;

    // counter wide enough to count header bits
    localparam int COUNT_BITS  = $clog2(LENGTH_BITS);

    // max_length after reset
    localparam logic [MAXLEN_BITS-1:0] MAX_LENGTH_RESET = MAXLEN_BITS'(1000);

    // status codes
    localparam logic STATUS_BYTE  = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

endpackage

[rtl/lsb_audio_message_extract.sv]
// ----------------------------------------------------------------------------
// LSB audio message extract
// Recovers a length-prefixed message from the LSBs of an audio sample stream.
// ----------------------------------------------------------------------------
// Latency: a result is valid in the cycle after the sample that completes it.
// Throughput: one sample per cycle; the state update and byte/header assembly
// sit between the state registers and the output register.
// A result waiting for out_ready holds off new samples until it is taken.
// Reset (rst_n low, asynchronous) clears all control state and sets
// max_length to 1000; the block then ignores samples until a first flag.
module lsb_audio_message_extract
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lsbame_pkg::MAXLEN_BITS-1:0]   max_length,
    // sample input
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [lsbame_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                 first,
    // result output
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [lsbame_pkg::BYTE_BITS-1:0]     data_byte,
    output logic                                 last,
    output logic                                 status
);

    typedef enum logic [1:0]
    {
        PH_IDLE,
        PH_HEADER,
        PH_DATA,
        PH_DONE
    } phase_t;

    phase_t                                   phase_reg,        phase_next;
    logic [lsbame_pkg::COUNT_BITS-1:0]        bit_count_reg,    bit_count_next;
    logic [lsbame_pkg::LENGTH_BITS-1:0]       length_shift_reg, length_shift_next;
    logic [lsbame_pkg::BYTE_BITS-1:0]         byte_shift_reg,   byte_shift_next;
    logic [lsbame_pkg::MAXLEN_BITS-1:0]       bytes_left_reg,   bytes_left_next;
    logic [lsbame_pkg::MAXLEN_BITS-1:0]       max_length_reg;

    logic                                     out_valid_reg,    out_valid_next;
    logic [lsbame_pkg::BYTE_BITS-1:0]         data_byte_reg,    data_byte_next;
    logic                                     last_reg,         last_next;
    logic                                     status_reg,       status_next;

    // working values: the state registers, or restart values on a first flag
    phase_t                                   ph_eff;
    logic [lsbame_pkg::COUNT_BITS-1:0]        cnt_eff;
    logic [lsbame_pkg::LENGTH_BITS-1:0]       len_eff;
    logic [lsbame_pkg::BYTE_BITS-1:0]         byte_eff;
    logic [lsbame_pkg::MAXLEN_BITS-1:0]       left_eff;

    logic                                     in_fire;
    logic                                     lsb;
    logic [lsbame_pkg::LENGTH_BITS-1:0]       len_new;
    logic [lsbame_pkg::BYTE_BITS-1:0]         byte_new;
    logic [lsbame_pkg::COUNT_BITS-1:0]        cnt_inc;
    logic [lsbame_pkg::MAXLEN_BITS-1:0]       left_dec;
    logic                                     len_bad;
    logic                                     emit;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign lsb       = sample[0];

    assign out_valid = out_valid_reg;
    assign data_byte = data_byte_reg;
    assign last      = last_reg;
    assign status    = status_reg;

    // first flag restarts decoding with this sample as header bit 0
    always_comb
    begin
        if (first)
        begin
            ph_eff   = PH_HEADER;
            cnt_eff  = '0;
            len_eff  = '0;
            byte_eff = '0;
            left_eff = '0;
        end
        else
        begin
            ph_eff   = phase_reg;
            cnt_eff  = bit_count_reg;
            len_eff  = length_shift_reg;
            byte_eff = byte_shift_reg;
            left_eff = bytes_left_reg;
        end
    end

    // shift in the LSB and check the header
    assign len_new  = {len_eff[lsbame_pkg::LENGTH_BITS-2:0], lsb};
    assign byte_new = {byte_eff[lsbame_pkg::BYTE_BITS-2:0], lsb};
    assign cnt_inc  = cnt_eff + 1'b1;
    assign left_dec = left_eff - 1'b1;
    assign len_bad  = len_new[lsbame_pkg::LENGTH_BITS-1]
                   || (len_new == '0)
                   || (len_new[lsbame_pkg::MAXLEN_BITS-1:0] > max_length_reg);

    // next state and result
    always_comb
    begin
        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        length_shift_next = length_shift_reg;
        byte_shift_next   = byte_shift_reg;
        bytes_left_next   = bytes_left_reg;
        emit              = 1'b0;
        data_byte_next    = data_byte_reg;
        last_next         = last_reg;
        status_next       = status_reg;

        if (in_fire)
        begin
            phase_next        = ph_eff;
            bit_count_next    = cnt_eff;
            length_shift_next = len_eff;
            byte_shift_next   = byte_eff;
            bytes_left_next   = left_eff;

            case (ph_eff)
                PH_HEADER:
                begin
                    length_shift_next = len_new;
                    if (cnt_eff != lsbame_pkg::COUNT_BITS'(lsbame_pkg::LENGTH_BITS - 1))
                    begin
                        bit_count_next = cnt_inc;
                    end
                    else
                    begin
                        bit_count_next = '0;
                        if (len_bad)
                        begin
                            phase_next     = PH_DONE;
                            emit           = 1'b1;
                            data_byte_next = '0;
                            last_next      = 1'b1;
                            status_next    = lsbame_pkg::STATUS_ERROR;
                        end
                        else
                        begin
                            bytes_left_next = len_new[lsbame_pkg::MAXLEN_BITS-1:0];
                            byte_shift_next = '0;
                            phase_next      = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    if (cnt_inc != lsbame_pkg::COUNT_BITS'(lsbame_pkg::BYTE_BITS))
                    begin
                        byte_shift_next = byte_new;
                        bit_count_next  = cnt_inc;
                    end
                    else
                    begin
                        // byte complete
                        byte_shift_next = '0;
                        bit_count_next  = '0;
                        bytes_left_next = left_dec;
                        emit            = 1'b1;
                        data_byte_next  = byte_new;
                        last_next       = (left_dec == '0);
                        status_next     = lsbame_pkg::STATUS_BYTE;
                        if (left_dec == '0)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                default:
                begin
                    // idle or finished: sample ignored
                end
            endcase
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            bit_count_reg    <= '0;
            length_shift_reg <= '0;
            byte_shift_reg   <= '0;
            bytes_left_reg   <= '0;
            max_length_reg   <= lsbame_pkg::MAX_LENGTH_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            bit_count_reg    <= bit_count_next;
            length_shift_reg <= length_shift_next;
            byte_shift_reg   <= byte_shift_next;
            bytes_left_reg   <= bytes_left_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                max_length_reg <= max_length;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        data_byte_reg <= data_byte_next;
        last_reg      <= last_next;
        status_reg    <= status_next;
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // error result carries last and a zero byte
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == lsbame_pkg::STATUS_ERROR) |-> last && (data_byte == '0))
        else $error("error result without last or with non-zero byte");

    // byte bit counter stays below one byte
    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |->
            (bit_count_reg < lsbame_pkg::COUNT_BITS'(lsbame_pkg::BYTE_BITS)))
        else $error("bit count overran a byte");

    // while reading bytes, at least one byte remains
    a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (bytes_left_reg != '0))
        else $error("data phase with no bytes left");

    // a new result only follows an accepted sample
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid && !out_ready) |-> $past(in_valid && in_ready))
        else $error("result appeared without an accepted sample");

endmodule

[tb/sv/tb_lsb_audio_message_extract.sv]
// ----------------------------------------------------------------------------
// Testbench for lsb_audio_message_extract
// Streams audio samples that carry length-prefixed messages in their LSBs,
// predicts the recovered bytes and header errors, and checks every result
// item against the prediction under random idling and output back-pressure.
// ----------------------------------------------------------------------------
module tb_lsb_audio_message_extract;

    timeunit 1ns;
    timeprecision 1ps;

    // cycles allowed for the last sample to work through after the queue empties
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 300;

    typedef enum logic [1:0] {DEC_IDLE, DEC_HEADER, DEC_BYTES, DEC_DONE} dec_phase_t;

    typedef struct packed {
        logic [lsbame_pkg::BYTE_BITS-1:0] data_byte;
        logic                             last;
        logic                             status;
    } msg_result_t;

    logic                                      clk = 1'b0;
    logic                                      rst_n = 1'b0;
    logic                                      cfg_valid = 1'b0;
    logic                                      cfg_ready;
    logic [lsbame_pkg::MAXLEN_BITS-1:0]        max_length = '0;
    logic                                      in_valid = 1'b0;
    logic                                      in_ready;
    logic signed [lsbame_pkg::SAMPLE_BITS-1:0] sample = '0;
    logic                                      first = 1'b0;
    logic                                      out_valid;
    logic                                      out_ready = 1'b0;
    logic [lsbame_pkg::BYTE_BITS-1:0]          data_byte;
    logic                                      last;
    logic                                      status;

    // decoder prediction state
    dec_phase_t                                dec_phase = DEC_IDLE;
    logic [lsbame_pkg::COUNT_BITS-1:0]         dec_bits = '0;
    logic [lsbame_pkg::LENGTH_BITS-1:0]        header_acc = '0;
    logic [lsbame_pkg::BYTE_BITS-1:0]          byte_acc = '0;
    logic [lsbame_pkg::MAXLEN_BITS-1:0]        bytes_remaining = '0;
    logic [lsbame_pkg::MAXLEN_BITS-1:0]        length_limit = lsbame_pkg::MAX_LENGTH_RESET;

    msg_result_t                               pending_results[$];
    int                                        fail_count = 0;
    int                                        samples_sent = 0;
    int                                        results_seen = 0;
    int                                        ready_hold = 0;
    bit                                        sender_idles = 1'b1;
    bit                                        receiver_idles = 1'b1;

    lsb_audio_message_extract i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .max_length(max_length),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .first     (first),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data_byte (data_byte),
        .last      (last),
        .status    (status)
    );

    // 125 MHz clock
    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // decode one accepted sample, queueing any result it completes
    task automatic decode_sample(input logic lsb, input logic restart);
        logic [lsbame_pkg::LENGTH_BITS-1:0] hdr;
        logic                               fin;
        if (restart)
        begin
            dec_phase       = DEC_HEADER;
            dec_bits        = '0;
            header_acc      = '0;
            byte_acc        = '0;
            bytes_remaining = '0;
        end
        case (dec_phase)
            DEC_HEADER:
            begin
                hdr        = {header_acc[lsbame_pkg::LENGTH_BITS-2:0], lsb};
                header_acc = hdr;
                if (dec_bits != lsbame_pkg::COUNT_BITS'(lsbame_pkg::LENGTH_BITS - 1))
                begin
                    dec_bits = dec_bits + 1'b1;
                end
                else
                begin
                    dec_bits = '0;
                    // negative, empty or oversized header
                    if (hdr[lsbame_pkg::LENGTH_BITS-1] || hdr == '0
                        || hdr[lsbame_pkg::MAXLEN_BITS-1:0] > length_limit)
                    begin
                        pending_results.push_back(msg_result_t'{data_byte: '0,
                            last: 1'b1, status: lsbame_pkg::STATUS_ERROR});
                        dec_phase = DEC_DONE;
                    end
                    else
                    begin
                        bytes_remaining = hdr[lsbame_pkg::MAXLEN_BITS-1:0];
                        byte_acc        = '0;
                        dec_phase       = DEC_BYTES;
                    end
                end
            end
            DEC_BYTES:
            begin
                byte_acc = {byte_acc[lsbame_pkg::BYTE_BITS-2:0], lsb};
                dec_bits = dec_bits + 1'b1;
                if (dec_bits == lsbame_pkg::COUNT_BITS'(lsbame_pkg::BYTE_BITS))
                begin
                    dec_bits        = '0;
                    bytes_remaining = bytes_remaining - 1'b1;
                    fin             = (bytes_remaining == '0);
                    pending_results.push_back(msg_result_t'{data_byte: byte_acc,
                        last: fin, status: lsbame_pkg::STATUS_BYTE});
                    if (fin)
                    begin
                        dec_phase = DEC_DONE;
                    end
                    byte_acc = '0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // offer one sample item and wait for it to be taken
    task automatic send_sample(input logic lsb, input logic restart);
        int                                 gap;
        logic [lsbame_pkg::SAMPLE_BITS-1:0] word;
        gap  = sender_idles ? $urandom_range(0, 7) : 0;
        word = lsbame_pkg::SAMPLE_BITS'($urandom);
        word[0] = lsb;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= word;
        first    <= restart;
        do
            @(posedge clk);
        while (!in_ready);
        samples_sent++;
        decode_sample(lsb, restart);
    endtask

    // send the low nbits of word as LSBs, MSB first
    task automatic send_bits(input logic [lsbame_pkg::LENGTH_BITS-1:0] word,
                             input int nbits, input logic restart);
        for (int i = nbits - 1; i >= 0; i--)
        begin
            send_sample(word[i], restart && (i == nbits - 1));
        end
    endtask

    // header followed by nbytes random message bytes
    task automatic send_message(input logic [lsbame_pkg::LENGTH_BITS-1:0] header,
                                input int nbytes);
        send_bits(header, lsbame_pkg::LENGTH_BITS, 1'b1);
        repeat (nbytes)
            send_bits(lsbame_pkg::LENGTH_BITS'($urandom_range(0, 255)),
                      lsbame_pkg::BYTE_BITS, 1'b0);
    endtask

    // stop offering, wait for every expected result, then let the block settle
    task automatic settle_outputs;
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write while the block is idle
    task automatic write_max_length(input logic [lsbame_pkg::MAXLEN_BITS-1:0] value);
        settle_outputs();
        cfg_valid  <= 1'b1;
        max_length <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        length_limit  = value;
    endtask

    // result checker
    initial
    begin : result_monitor
        int          stall;
        msg_result_t want;
        forever
        begin
            stall = receiver_idles ? $urandom_range(0, 7) : 0;
            if (stall > 0 || ready_hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (ready_hold > 0)
                begin
                    @(posedge clk);
                    ready_hold--;
                end
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result data_byte %02h last %0b status %0b",
                         $time, data_byte, last, status);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (data_byte !== want.data_byte)
                begin
                    $display("%0t: data_byte expected %02h actual %02h",
                             $time, want.data_byte, data_byte);
                    fail_count++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last expected %0b actual %0b", $time, want.last, last);
                    fail_count++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0b actual %0b",
                             $time, want.status, status);
                    fail_count++;
                end
            end
        end
    end

    // samples before any first flag are ignored; then a basic two byte message
    task automatic test_ignored_before_first;
        send_bits(lsbame_pkg::LENGTH_BITS'($urandom), 6, 1'b0);
        send_bits(32'd2, lsbame_pkg::LENGTH_BITS, 1'b1);
        send_bits(32'h00, lsbame_pkg::BYTE_BITS, 1'b0);
        send_bits(32'hFF, lsbame_pkg::BYTE_BITS, 1'b0);
        // ignored after completion
        send_bits(lsbame_pkg::LENGTH_BITS'($urandom), 5, 1'b0);
        settle_outputs();
    endtask

    // zero, negative, at-limit and over-limit headers at the reset limit
    task automatic test_header_extremes;
        send_message(32'd0, 0);
        send_message(32'h8000_0000, 0);
        send_message(32'hFFFF_FFFF, 0);
        // ignored after an error
        send_bits(lsbame_pkg::LENGTH_BITS'($urandom), 5, 1'b0);
        send_message(32'd1001, 0);
        send_message(32'd1000, 2);
        send_message(32'd1, 1);
        settle_outputs();
    endtask

    // restarts inside header and body, and a stream cut short
    task automatic test_restart_and_truncation;
        send_bits(32'd3, 10, 1'b1);
        send_message(32'd3, 1);
        send_bits(lsbame_pkg::LENGTH_BITS'($urandom), 4, 1'b0);
        send_message(32'd2, 2);
        send_message(32'd5, 2);
        settle_outputs();
        send_message(32'd1, 1);
        settle_outputs();
    endtask

    // register at zero, one and its top value
    task automatic test_register_limits;
        write_max_length('0);
        send_message(32'd1, 1);
        write_max_length(31'h7FFF_FFFF);
        send_message(32'h7FFF_FFFF, 2);
        send_message(32'h8000_0000, 0);
        write_max_length(31'd1);
        send_message(32'd1, 1);
        send_message(32'd2, 0);
        settle_outputs();
    endtask

    // receiver holds off for a long stretch while samples keep coming
    task automatic test_output_backpressure;
        write_max_length(lsbame_pkg::MAX_LENGTH_RESET);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        ready_hold     = HOLD_CYCLES;
        send_message(32'd24, 24);
        settle_outputs();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    // mostly well formed messages, with truncations, bad headers and noise
    task automatic test_random_streams;
        int                                 sent_goal;
        int                                 result_goal;
        int                                 msg_idx;
        int                                 kind;
        longint                             cap;
        int                                 len;
        int                                 body_bits;
        logic [lsbame_pkg::LENGTH_BITS-1:0] hdr;
        sent_goal   = samples_sent + 300;
        result_goal = results_seen + 15;
        msg_idx     = 0;
        while (samples_sent < sent_goal || results_seen < result_goal)
        begin
            // occasional new limit between messages
            if (msg_idx % 4 == 3)
            begin
                case ($urandom_range(0, 4))
                    0:       write_max_length(31'd1);
                    1:       write_max_length(lsbame_pkg::MAX_LENGTH_RESET);
                    2:       write_max_length(31'h7FFF_FFFF);
                    3:       write_max_length(lsbame_pkg::MAXLEN_BITS'($urandom));
                    default: write_max_length(lsbame_pkg::MAXLEN_BITS'($urandom_range(2, 20)));
                endcase
            end
            if (msg_idx % 3 == 0)
            begin
                sender_idles   = ($urandom_range(0, 3) != 0);
                receiver_idles = ($urandom_range(0, 3) != 0);
            end
            cap = ($urandom_range(0, 7) == 0) ? 40 : 6;
            if (longint'(length_limit) < cap)
            begin
                cap = length_limit;
            end
            len  = (cap < 1) ? 1 : $urandom_range(1, int'(cap));
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                send_message(lsbame_pkg::LENGTH_BITS'(len), len);
            end
            else if (kind == 7)
            begin
                // cut short in the header or in the body
                if ($urandom_range(0, 1) == 0)
                begin
                    send_bits(lsbame_pkg::LENGTH_BITS'($urandom), $urandom_range(1, 31), 1'b1);
                end
                else
                begin
                    body_bits = 8 * len - 1;
                    if (body_bits > lsbame_pkg::LENGTH_BITS - 1)
                    begin
                        body_bits = lsbame_pkg::LENGTH_BITS - 1;
                    end
                    send_message(lsbame_pkg::LENGTH_BITS'(len), 0);
                    send_bits(lsbame_pkg::LENGTH_BITS'($urandom),
                              $urandom_range(0, body_bits), 1'b0);
                end
            end
            else if (kind == 8)
            begin
                case ($urandom_range(0, 3))
                    0:       hdr = '0;
                    1:       hdr = lsbame_pkg::LENGTH_BITS'($urandom) | 32'h8000_0000;
                    2:       hdr = {1'b0, length_limit} + 1'b1;
                    default: hdr = lsbame_pkg::LENGTH_BITS'($urandom);
                endcase
                send_message(hdr, (hdr > 0 && hdr <= 32'd8) ? int'(hdr) : 0);
            end
            else
            begin
                send_bits(lsbame_pkg::LENGTH_BITS'($urandom), $urandom_range(1, 12), 1'b0);
            end
            msg_idx++;
        end
        settle_outputs();
    endtask

    // stimulus sequence
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_ignored_before_first();
        test_header_extremes();
        test_restart_and_truncation();
        test_register_limits();
        test_output_backpressure();
        test_random_streams();
        settle_outputs();
        if (fail_count == 0 && pending_results.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
rtl/lsbame_pkg.sv
rtl/lsb_audio_message_extract.sv
tb/sv/tb_lsb_audio_message_extract.sv
